[rtl/ccs_pkg.sv]
// shared types and constants of the c comment stripper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ccs_pkg;

    // character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // depth of the result queue, two entries at least
    localparam int CCS_FIFO_DEPTH = 4;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } ccs_mode_t;

    // up to two bytes produced by one request
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] data0;
        logic [7:0] data1;
    } ccs_result_t;

    // one queued result
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ccs_entry_t;

endpackage

`default_nettype wire

[rtl/ccs_scan.sv]
// scanner state and per-byte comment removal logic
// depends on ccs_pkg
`timescale 1ns / 1ps
`default_nettype none

module ccs_scan
    import ccs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    output ccs_result_t      result
);

    ccs_mode_t   mode_reg, mode_next;
    logic        str_reg, str_next;
    logic        chr_reg, chr_next;
    logic [7:0]  prev_reg;

    logic        dq_hit;
    logic        sq_hit;
    logic [1:0]  n;
    logic [7:0]  d0, d1;

    // quote toggles when the byte goes out as plain text
    assign dq_hit = !chr_reg && in_byte == CH_DQUOTE && prev_reg != CH_BSLASH;
    assign sq_hit = !str_reg && in_byte == CH_SQUOTE && prev_reg != CH_BSLASH;

    // next mode and emitted bytes
    always_comb
    begin
        mode_next = mode_reg;
        str_next  = str_reg;
        chr_next  = chr_reg;
        n         = 2'd0;
        d0        = CH_SPACE;
        d1        = in_byte;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_LINE;
                end
                else if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                    if (is_last)
                    begin
                        n = 2'd1;
                    end
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    n         = 2'd2;
                    d0        = CH_SLASH;
                    str_next  = str_reg ^ dq_hit;
                    chr_next  = chr_reg ^ sq_hit;
                end
            end
            MODE_LINE:
            begin
                if (in_byte == CH_NL)
                begin
                    mode_next = MODE_NORMAL;
                    n         = 2'd1;
                    d0        = in_byte;
                end
            end
            MODE_BLOCK, MODE_STAR:
            begin
                if (is_last)
                begin
                    // literal state is cleared at stream end anyway
                    if (mode_reg == MODE_STAR && in_byte == CH_SLASH)
                    begin
                        n = 2'd1;
                    end
                    else
                    begin
                        n = 2'd2;
                    end
                end
                else if (mode_reg == MODE_STAR && in_byte == CH_SLASH)
                begin
                    mode_next = MODE_NORMAL;
                    n         = 2'd1;
                end
                else if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_STAR;
                end
                else
                begin
                    mode_next = MODE_BLOCK;
                    if (in_byte == CH_NL)
                    begin
                        n  = 2'd1;
                        d0 = CH_NL;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                if (!str_reg && !chr_reg && in_byte == CH_SLASH)
                begin
                    if (is_last)
                    begin
                        n  = 2'd1;
                        d0 = CH_SLASH;
                    end
                    else
                    begin
                        mode_next = MODE_SLASH;
                    end
                end
                else
                begin
                    n        = 2'd1;
                    d0       = in_byte;
                    str_next = str_reg ^ dq_hit;
                    chr_next = chr_reg ^ sq_hit;
                end
            end
        endcase
    end

    assign result.count = accept ? n : 2'd0;
    assign result.data0 = d0;
    assign result.data1 = d1;

    // scanner state, cleared after the last byte of a stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            str_reg  <= 1'b0;
            chr_reg  <= 1'b0;
            prev_reg <= 8'h00;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                mode_reg <= MODE_NORMAL;
                str_reg  <= 1'b0;
                chr_reg  <= 1'b0;
                prev_reg <= 8'h00;
            end
            else
            begin
                mode_reg <= mode_next;
                str_reg  <= str_next;
                chr_reg  <= chr_next;
                prev_reg <= in_byte;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/c_comment_stripper.sv]
// Streams source text one byte per cycle while in_ready is high and
// removes C and C++ comments. A request is taken in any cycle in which the
// result queue has room for two bytes; the scanner decides a byte
// combinationally and writes zero, one or two bytes into a FIFO_DEPTH-entry
// result queue. Output is one byte per cycle while out_ready is high, so a
// run of two-byte requests is limited by the output side. A byte reaches the
// head of an empty queue in the cycle after acceptance. run_last marks the
// last byte produced by each request; requests that produce nothing give
// no result. All scanner state clears after a byte flagged is_last.
// depends on ccs_pkg and ccs_scan
`timescale 1ns / 1ps
`default_nettype none

module c_comment_stripper
    import ccs_pkg::*;
#(
    parameter int FIFO_DEPTH = CCS_FIFO_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             run_last
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(FIFO_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    ccs_result_t      result;
    ccs_entry_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic             accept;
    logic             pop;

    assign in_ready = count_reg <= CNT_ROOM;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;

    // per-byte scanner
    ccs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .is_last (is_last),
        .result  (result)
    );

    // queue pointers and fill count
    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (result.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(result.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, up to two writes a cycle
    always_ff @(posedge clk)
    begin
        if (result.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= '{data: result.data0, last: result.count == 2'd1};
        end
        if (result.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= '{data: result.data1, last: 1'b1};
        end
    end

    // queue head drives the output
    assign out_valid = count_reg != '0;
    assign out_byte  = mem_reg[rd_ptr_reg].data;
    assign run_last  = mem_reg[rd_ptr_reg].last;

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("result queue overflow");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> result.count == 2'd0)
        else $error("result written without an accepted request");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        result.count != 2'd0 |=> out_valid)
        else $error("written result not visible at the output");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (result.count == 2'd0 || count_next != '0))
        else $error("result queue underflow");

endmodule

`default_nettype wire
